// ----- rtl/cbse_pkg.sv -----
package cbse_pkg;

   localparam int COORD_BITS        = 24;
   localparam int INDEX_BITS        = 7;
   localparam int POS_BITS          = 17;
   localparam int SEG_COUNT_BITS    = 6;
   localparam int ROW_BITS          = 6;
   localparam int CBSE_MAX_SEGMENTS = 32;
   localparam int NUM_STAGES        = 6;

   // Weights are Q0.24 and reach 1.0, hence one bit above the fraction.
   localparam int ROUND_SHIFT  = 24;
   localparam int WEIGHT_BITS  = ROUND_SHIFT + 1;
   localparam int SQ_BITS      = 2 * POS_BITS - 1;
   localparam int CUBE_BITS    = 3 * POS_BITS - 2;
   localparam int TRI_BITS     = CUBE_BITS + 2;
   localparam int PROD_BITS    = WEIGHT_BITS + COORD_BITS - 1;
   localparam int ACC_BITS     = PROD_BITS + 2;
   localparam int RND_BITS     = ACC_BITS - ROUND_SHIFT;

   localparam logic [POS_BITS-1:0] ONE_Q16 = POS_BITS'(65536);

   localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS - 1){1'b1}}};
   localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS - 1){1'b0}}};

   typedef enum logic {
      CMD_WRITE = 1'b0,
      CMD_EVAL  = 1'b1
   } cmd_type;

   // Point p lives in bank p mod 3, row p div 3.
   typedef enum logic [1:0] {
      BANK_0 = 2'd0,
      BANK_1 = 2'd1,
      BANK_2 = 2'd2
   } bank_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [COORD_BITS-1:0] z;
   } point_type;

   typedef point_type [3:0] point_set_type;
   typedef logic [3:0][WEIGHT_BITS-1:0] weight_set_type;
   typedef logic [3:0][COORD_BITS-1:0] coord_set_type;

   typedef struct packed {
      logic                wr_en;
      bank_type            wr_bank;
      logic [ROW_BITS-1:0] row;
      logic [ROW_BITS-1:0] row_next;
   } locate_type;

   typedef struct packed {
      logic [NUM_STAGES:1] load;
      logic [NUM_STAGES:1] valid;
   } pipe_ctl_type;

endpackage

// ----- rtl/cbse_ifs.sv -----
interface cbse_req_if import cbse_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic                         cmd;
   logic [INDEX_BITS-1:0]        point_index;
   logic signed [COORD_BITS-1:0] coord_x;
   logic signed [COORD_BITS-1:0] coord_y;
   logic signed [COORD_BITS-1:0] coord_z;
   logic [POS_BITS-1:0]          curve_position;

   modport source (
      output valid, cmd, point_index, coord_x, coord_y, coord_z, curve_position,
      input  ready
   );
   modport sink (
      input  valid, cmd, point_index, coord_x, coord_y, coord_z, curve_position,
      output ready
   );
endinterface

interface cbse_rsp_if import cbse_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] out_x;
   logic signed [COORD_BITS-1:0] out_y;
   logic signed [COORD_BITS-1:0] out_z;

   modport source (
      output valid, out_x, out_y, out_z,
      input  ready
   );
   modport sink (
      input  valid, out_x, out_y, out_z,
      output ready
   );
endinterface

interface cbse_csr_if import cbse_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [SEG_COUNT_BITS-1:0] segment_count;

   modport source (
      output valid, segment_count,
      input  ready
   );
   modport sink (
      input  valid, segment_count,
      output ready
   );
endinterface

// ----- rtl/closed_bezier_spline_eval_core.sv -----
// Closed cubic Bezier curve evaluator.
// req_bus carries two kinds of beat. cmd = write stores control point
// point_index (X, Y, Z in signed Q15.8); cmd = eval asks for the curve point
// at curve_position (Q0.16, 65536 is the end of the curve) and gives one
// beat on rsp_bus. csr_bus sets segment_count, three stored points per
// segment; the last segment closes back onto point 0. It is always ready.
// Points live in three banks by index mod 3; bank 0 has two read ports, so
// all four points of a segment come out of the store in the same cycle.
// The pipeline has six register stages and takes one beat every cycle while
// rsp_bus is not stalled. An eval result is offered from the sixth stage.
// A write beat reaches the store at the third stage and then leaves.
// Each stage moves only when the one after it is empty or moving, so
// bubbles close up and rsp_bus holds its beat while ready is low; req_bus
// stays ready while some stage has room. Reset empties the pipeline and
// sets segment_count to 1; the store is not cleared, and a point must be
// written before an eval reads it.
module closed_bezier_spline_eval_core import cbse_pkg::*; #(
   parameter int MAX_SEGMENTS = CBSE_MAX_SEGMENTS
) (
   input  logic       clock,
   input  logic       reset,
   cbse_req_if.sink   req_bus,
   cbse_rsp_if.source rsp_bus,
   cbse_csr_if.sink   csr_bus
);

   logic [SEG_COUNT_BITS-1:0] seg_count_ff;
   logic [NUM_STAGES:1]       valid_ff, valid_in;
   logic [3:1]                eval_ff, eval_in;
   pipe_ctl_type              pipe;

   locate_type                s1_ctl;
   point_type                 s1_pt;
   logic [POS_BITS-1:0]       s1_frac, s1_rest;
   weight_set_type            s4_wt;
   point_set_type             s4_pts;
   coord_set_type             x_set, y_set, z_set;
   logic [COORD_BITS-1:0]     out_x, out_y, out_z;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_count_ff <= SEG_COUNT_BITS'(1);
      end else if (csr_bus.valid) begin
         seg_count_ff <= csr_bus.segment_count;
      end
   end

   always_comb begin
      pipe.load[NUM_STAGES] = !valid_ff[NUM_STAGES] || rsp_bus.ready;
      for (int k = NUM_STAGES - 1; k >= 1; k--) begin
         pipe.load[k] = !valid_ff[k] || pipe.load[k + 1];
      end
      pipe.valid = valid_ff;
   end

   always_comb begin
      valid_in = valid_ff;
      eval_in  = eval_ff;
      if (pipe.load[1]) begin
         valid_in[1] = req_bus.valid;
         eval_in[1]  = (req_bus.cmd == CMD_EVAL);
      end
      if (pipe.load[2]) begin
         valid_in[2] = valid_ff[1];
         eval_in[2]  = eval_ff[1];
      end
      if (pipe.load[3]) begin
         valid_in[3] = valid_ff[2];
         eval_in[3]  = eval_ff[2];
      end
      // Write beats are done once they pass the store.
      if (pipe.load[4]) begin
         valid_in[4] = valid_ff[3] && eval_ff[3];
      end
      for (int k = 5; k <= NUM_STAGES; k++) begin
         if (pipe.load[k]) begin
            valid_in[k] = valid_ff[k - 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         eval_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         eval_ff  <= eval_in;
      end
   end

   assign req_bus.ready = pipe.load[1];

   cbse_locate #(
      .MAX_SEGMENTS (MAX_SEGMENTS)
   ) u_locate (
      .clock          (clock),
      .pipe           (pipe),
      .seg_count      (seg_count_ff),
      .cmd            (req_bus.cmd),
      .point_index    (req_bus.point_index),
      .coord_x        (req_bus.coord_x),
      .coord_y        (req_bus.coord_y),
      .coord_z        (req_bus.coord_z),
      .curve_position (req_bus.curve_position),
      .s1_ctl         (s1_ctl),
      .s1_pt          (s1_pt),
      .s1_frac        (s1_frac),
      .s1_rest        (s1_rest)
   );

   cbse_weights u_weights (
      .clock   (clock),
      .pipe    (pipe),
      .s1_frac (s1_frac),
      .s1_rest (s1_rest),
      .s4_wt   (s4_wt)
   );

   cbse_store #(
      .MAX_SEGMENTS (MAX_SEGMENTS)
   ) u_store (
      .clock  (clock),
      .reset  (reset),
      .pipe   (pipe),
      .s1_ctl (s1_ctl),
      .s1_pt  (s1_pt),
      .s4_pts (s4_pts)
   );

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         x_set[k] = s4_pts[k].x;
         y_set[k] = s4_pts[k].y;
         z_set[k] = s4_pts[k].z;
      end
   end

   cbse_blend u_blend_x (
      .clock     (clock),
      .pipe      (pipe),
      .wt        (s4_wt),
      .coords    (x_set),
      .out_coord (out_x)
   );

   cbse_blend u_blend_y (
      .clock     (clock),
      .pipe      (pipe),
      .wt        (s4_wt),
      .coords    (y_set),
      .out_coord (out_y)
   );

   cbse_blend u_blend_z (
      .clock     (clock),
      .pipe      (pipe),
      .wt        (s4_wt),
      .coords    (z_set),
      .out_coord (out_z)
   );

   assign rsp_bus.valid = valid_ff[NUM_STAGES];
   assign rsp_bus.out_x = out_x;
   assign rsp_bus.out_y = out_y;
   assign rsp_bus.out_z = out_z;

   a_write_no_result: assert property (@(posedge clock) disable iff (reset)
      valid_ff[3] && !eval_ff[3] && pipe.load[4] |=> !valid_ff[4])
      else $error("write beat reached the blend stages");

   a_ready_when_room: assert property (@(posedge clock) disable iff (reset)
      !valid_ff[1] |-> req_bus.ready)
      else $error("input stalled with an empty first stage");

   a_no_repeat: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.ready && !valid_ff[NUM_STAGES - 1] |=> !rsp_bus.valid)
      else $error("result beat repeated");

   a_count_reset: assert property (@(posedge clock)
      reset |=> seg_count_ff == SEG_COUNT_BITS'(1))
      else $error("segment count not one after reset");

endmodule

// ----- rtl/cbse_locate.sv -----
module cbse_locate import cbse_pkg::*; #(
   parameter int MAX_SEGMENTS = CBSE_MAX_SEGMENTS
) (
   input  logic                         clock,
   input  pipe_ctl_type                 pipe,
   input  logic [SEG_COUNT_BITS-1:0]    seg_count,
   input  logic                         cmd,
   input  logic [INDEX_BITS-1:0]        point_index,
   input  logic signed [COORD_BITS-1:0] coord_x,
   input  logic signed [COORD_BITS-1:0] coord_y,
   input  logic signed [COORD_BITS-1:0] coord_z,
   input  logic [POS_BITS-1:0]          curve_position,
   output locate_type                   s1_ctl,
   output point_type                    s1_pt,
   output logic [POS_BITS-1:0]          s1_frac,
   output logic [POS_BITS-1:0]          s1_rest
);

   localparam int STORE_DEPTH = 3 * MAX_SEGMENTS;
   // Division of a 7-bit slot number by three: multiply by 43, drop 7 bits.
   localparam int DIV3_MUL    = 43;
   localparam int DIV3_SHIFT  = 7;
   localparam int SLOT_BITS   = INDEX_BITS + DIV3_SHIFT - 1;

   logic [ROW_BITS-1:0]       segs;
   logic [POS_BITS-1:0]       pos;
   logic [ROW_BITS+15:0]      scaled;
   logic [ROW_BITS-1:0]       seg_raw;
   logic [ROW_BITS-1:0]       seg;
   logic [POS_BITS-1:0]       frac;
   logic [SLOT_BITS-1:0]      slot_prod;
   logic [ROW_BITS-1:0]       slot_row;
   logic [INDEX_BITS-1:0]     slot_rem;
   logic                      slot_ok;

   locate_type                ctl_ff, ctl_in;
   point_type                 pt_ff;
   logic [POS_BITS-1:0]       frac_ff, rest_ff;

   always_comb begin
      if (seg_count == '0) begin
         segs = ROW_BITS'(1);
      end else if (int'(seg_count) > MAX_SEGMENTS) begin
         segs = ROW_BITS'(MAX_SEGMENTS);
      end else begin
         segs = ROW_BITS'(seg_count);
      end

      pos     = (curve_position > ONE_Q16) ? ONE_Q16 : curve_position;
      scaled  = (ROW_BITS + 16)'(segs * pos);
      seg_raw = scaled[16 +: ROW_BITS];

      // Position one lands past the end: take the last segment at its far end.
      if (seg_raw >= segs) begin
         seg  = segs - ROW_BITS'(1);
         frac = ONE_Q16;
      end else begin
         seg  = seg_raw;
         frac = {1'b0, scaled[15:0]};
      end

      slot_prod = SLOT_BITS'(point_index) * SLOT_BITS'(DIV3_MUL);
      slot_row  = slot_prod[DIV3_SHIFT +: ROW_BITS];
      slot_rem  = point_index - INDEX_BITS'(3 * slot_row);
      slot_ok   = int'(point_index) < STORE_DEPTH;

      if (cmd == CMD_EVAL) begin
         ctl_in.wr_en    = 1'b0;
         ctl_in.wr_bank  = BANK_0;
         ctl_in.row      = seg;
         ctl_in.row_next = (seg == segs - ROW_BITS'(1)) ? '0 : seg + ROW_BITS'(1);
      end else begin
         // A dropped write keeps its rows inside the banks.
         ctl_in.wr_en    = slot_ok;
         ctl_in.wr_bank  = bank_type'(slot_rem[1:0]);
         ctl_in.row      = slot_ok ? slot_row : '0;
         ctl_in.row_next = slot_ok ? slot_row : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe.load[1]) begin
         ctl_ff  <= ctl_in;
         pt_ff   <= '{x: coord_x, y: coord_y, z: coord_z};
         frac_ff <= frac;
         rest_ff <= ONE_Q16 - frac;
      end
   end

   assign s1_ctl  = ctl_ff;
   assign s1_pt   = pt_ff;
   assign s1_frac = frac_ff;
   assign s1_rest = rest_ff;

endmodule

// ----- rtl/cbse_weights.sv -----
module cbse_weights import cbse_pkg::*; (
   input  logic                clock,
   input  pipe_ctl_type        pipe,
   input  logic [POS_BITS-1:0] s1_frac,
   input  logic [POS_BITS-1:0] s1_rest,
   output weight_set_type      s4_wt
);

   localparam logic [TRI_BITS-1:0] RoundHalf = TRI_BITS'(1) << (ROUND_SHIFT - 1);

   logic [SQ_BITS-1:0]   uu_ff, uf_ff, ff_ff;
   logic [POS_BITS-1:0]  frac_ff, rest_ff;
   logic [CUBE_BITS-1:0] cube_ff [4];
   logic [TRI_BITS-1:0]  scaled [4];
   weight_set_type       wt_ff, wt_in;

   always_ff @(posedge clock) begin
      if (pipe.load[2]) begin
         uu_ff   <= SQ_BITS'(s1_rest * s1_rest);
         uf_ff   <= SQ_BITS'(s1_rest * s1_frac);
         ff_ff   <= SQ_BITS'(s1_frac * s1_frac);
         frac_ff <= s1_frac;
         rest_ff <= s1_rest;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe.load[3]) begin
         cube_ff[0] <= CUBE_BITS'(uu_ff * rest_ff);
         cube_ff[1] <= CUBE_BITS'(uu_ff * frac_ff);
         cube_ff[2] <= CUBE_BITS'(uf_ff * frac_ff);
         cube_ff[3] <= CUBE_BITS'(ff_ff * frac_ff);
      end
   end

   // The two middle Bernstein terms carry a factor of three.
   always_comb begin
      scaled[0] = TRI_BITS'(cube_ff[0]) + RoundHalf;
      scaled[1] = TRI_BITS'(cube_ff[1]) + TRI_BITS'({cube_ff[1], 1'b0}) + RoundHalf;
      scaled[2] = TRI_BITS'(cube_ff[2]) + TRI_BITS'({cube_ff[2], 1'b0}) + RoundHalf;
      scaled[3] = TRI_BITS'(cube_ff[3]) + RoundHalf;
      for (int k = 0; k < 4; k++) begin
         wt_in[k] = scaled[k][ROUND_SHIFT +: WEIGHT_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe.load[4]) begin
         wt_ff <= wt_in;
      end
   end

   assign s4_wt = wt_ff;

endmodule

// ----- rtl/cbse_store.sv -----
module cbse_store import cbse_pkg::*; #(
   parameter int MAX_SEGMENTS = CBSE_MAX_SEGMENTS
) (
   input  logic          clock,
   input  logic          reset,
   input  pipe_ctl_type  pipe,
   input  locate_type    s1_ctl,
   input  point_type     s1_pt,
   output point_set_type s4_pts
);

   localparam int ADDR_BITS = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

   locate_type          ctl_ff;
   point_type           pt_ff;
   point_type           bank0_mem [MAX_SEGMENTS];
   point_type           bank1_mem [MAX_SEGMENTS];
   point_type           bank2_mem [MAX_SEGMENTS];
   point_set_type       rd_ff, pts_ff;
   logic [ADDR_BITS-1:0] row_addr, next_addr;

   always_ff @(posedge clock) begin
      if (pipe.load[2]) begin
         ctl_ff <= s1_ctl;
         pt_ff  <= s1_pt;
      end
   end

   assign row_addr  = ADDR_BITS'(ctl_ff.row);
   assign next_addr = ADDR_BITS'(ctl_ff.row_next);

   // Writes and reads happen at the same stage, so they keep beat order.
   always_ff @(posedge clock) begin
      if (pipe.load[3] && pipe.valid[2] && ctl_ff.wr_en) begin
         unique case (ctl_ff.wr_bank)
            BANK_0:  bank0_mem[row_addr] <= pt_ff;
            BANK_1:  bank1_mem[row_addr] <= pt_ff;
            BANK_2:  bank2_mem[row_addr] <= pt_ff;
            default: ;
         endcase
      end
   end

   // Bank 0 has a second read port for the closing point of each segment.
   always_ff @(posedge clock) begin
      if (pipe.load[3]) begin
         rd_ff[0] <= bank0_mem[row_addr];
         rd_ff[1] <= bank1_mem[row_addr];
         rd_ff[2] <= bank2_mem[row_addr];
         rd_ff[3] <= bank0_mem[next_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe.load[4]) begin
         pts_ff <= rd_ff;
      end
   end

   assign s4_pts = pts_ff;

   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      pipe.valid[2] |-> (int'(ctl_ff.row) < MAX_SEGMENTS)
                        && (int'(ctl_ff.row_next) < MAX_SEGMENTS))
      else $error("store row outside the banks");

endmodule

// ----- rtl/cbse_blend.sv -----
module cbse_blend import cbse_pkg::*; (
   input  logic                  clock,
   input  pipe_ctl_type          pipe,
   input  weight_set_type        wt,
   input  coord_set_type         coords,
   output logic [COORD_BITS-1:0] out_coord
);

   localparam logic signed [ACC_BITS-1:0] RoundBias = ACC_BITS'(1) << (ROUND_SHIFT - 1);

   logic signed [PROD_BITS-1:0] prod_ff [4];
   logic signed [PROD_BITS-1:0] prod_in [4];
   logic signed [ACC_BITS-1:0]  acc;
   logic signed [ACC_BITS-1:0]  shifted;
   logic signed [RND_BITS-1:0]  rnd;
   logic [COORD_BITS-1:0]       out_ff, out_in;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         prod_in[k] = PROD_BITS'($signed({1'b0, wt[k]}) * $signed(coords[k]));
      end
   end

   always_ff @(posedge clock) begin
      if (pipe.load[5]) begin
         for (int k = 0; k < 4; k++) begin
            prod_ff[k] <= prod_in[k];
         end
      end
   end

   // Round half up, then clip: the rounded weights may sum a little above one.
   always_comb begin
      acc = RoundBias;
      for (int k = 0; k < 4; k++) begin
         acc = acc + ACC_BITS'(prod_ff[k]);
      end
      shifted = acc >>> ROUND_SHIFT;
      rnd     = shifted[RND_BITS-1:0];
      if (rnd > COORD_MAX) begin
         out_in = COORD_MAX;
      end else if (rnd < COORD_MIN) begin
         out_in = COORD_MIN;
      end else begin
         out_in = rnd[COORD_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe.load[6]) begin
         out_ff <= out_in;
      end
   end

   assign out_coord = out_ff;

endmodule
